// ----- rtl/core/esc_pkg.sv -----
// shared types and constants of the environmental sensor compensation block
`timescale 1ns / 1ps
package esc_pkg;

  localparam int RAW_T_W  = 20;
  localparam int RAW_P_W  = 20;
  localparam int RAW_H_W  = 16;
  localparam int TEMP_W   = 16;
  localparam int PRESS_W  = 24;
  localparam int HUM_W    = 17;
  localparam int COEFF_W  = 48;
  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;

  // pipeline layout: stage k holds the results of k register steps
  localparam int N_STAGES   = 80;
  localparam int DIV_STAGES = 64;
  localparam int ST_TEMP    = 4;
  localparam int ST_DZ      = 10;
  localparam int ST_HUM     = 12;

  localparam logic [RAW_T_W-1:0] TEMP_SKIP_CODE  = 20'h80000;
  localparam logic [RAW_P_W-1:0] PRESS_SKIP_CODE = 20'h80000;
  localparam logic [RAW_H_W-1:0] HUM_SKIP_CODE   = 16'h8000;
  localparam logic signed [63:0] HUM_CLAMP_MAX   = 64'sd419430400;

  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_C = 3'd3,
    REG_HUM_A   = 3'd4,
    REG_HUM_B   = 3'd5
  } reg_idx_e;

  // side data that travels down the pipeline with each sample set
  typedef struct packed {
    logic [RAW_P_W-1:0]       rp;
    logic [RAW_H_W-1:0]       rh;
    logic                     t_skip;
    logic                     p_skip;
    logic                     h_skip;
    logic                     dz;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
  } sb_t;

endpackage

// ----- rtl/core/esc_sample_if.sv -----
// input channel: one set of raw sensor readings
`timescale 1ns / 1ps
interface esc_sample_if;
  logic                        valid;
  logic                        ready;
  logic [esc_pkg::RAW_T_W-1:0] raw_temperature;
  logic [esc_pkg::RAW_P_W-1:0] raw_pressure;
  logic [esc_pkg::RAW_H_W-1:0] raw_humidity;

  modport source (output valid, output raw_temperature, output raw_pressure,
                  output raw_humidity, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure,
                input raw_humidity, output ready);
endinterface

// ----- rtl/core/esc_result_if.sv -----
// output channel: one set of compensated readings and flags
`timescale 1ns / 1ps
interface esc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [esc_pkg::TEMP_W-1:0]  temperature_centi;
  logic [esc_pkg::PRESS_W-1:0]        pressure_pa;
  logic [esc_pkg::HUM_W-1:0]          humidity_q10;
  logic                               temp_skipped;
  logic                               press_skipped;
  logic                               hum_skipped;
  logic                               press_div_zero;

  modport source (output valid, output temperature_centi, output pressure_pa,
                  output humidity_q10, output temp_skipped, output press_skipped,
                  output hum_skipped, output press_div_zero, input ready);
  modport sink (input valid, input temperature_centi, input pressure_pa,
                input humidity_q10, input temp_skipped, input press_skipped,
                input hum_skipped, input press_div_zero, output ready);
endinterface

// ----- rtl/core/env_sensor_compensation.sv -----
// integer temperature, pressure and humidity compensation pipeline
//
// channel    dir  handshake       payload
// sample_i   in   valid/ready     raw_temperature, raw_pressure, raw_humidity
// result_o   out  valid/ready     temperature_centi, pressure_pa, humidity_q10, flags
// apb        in   psel/penable    coefficient registers at byte address 8*i
//
// one sample set enters per cycle while the result output is not stalled
// the pressure divider forms most of the pipeline: 64 stages, one quotient bit per stage
// reset clears the stage valid bits and the coefficient registers
// a stalled result holds the whole pipeline in place; nothing is dropped or repeated
`timescale 1ns / 1ps
module env_sensor_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  esc_sample_if.sink                    sample_i,
  esc_result_if.source                  result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esc_pkg::ADDR_W-1:0]    paddr,
  input  logic [esc_pkg::DATA_W-1:0]    pwdata,
  output logic [esc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int NS = esc_pkg::N_STAGES;
  localparam int ND = esc_pkg::DIV_STAGES;

  // ---------------- configuration registers ----------------
  logic [esc_pkg::COEFF_W-1:0] cfg_q [esc_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < esc_pkg::NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (esc_pkg::reg_idx_e'(paddr[5:3]))
        esc_pkg::REG_TEMP:    cfg_q[esc_pkg::REG_TEMP]    <= pwdata[47:0];
        esc_pkg::REG_PRESS_A: cfg_q[esc_pkg::REG_PRESS_A] <= pwdata[47:0];
        esc_pkg::REG_PRESS_B: cfg_q[esc_pkg::REG_PRESS_B] <= pwdata[47:0];
        esc_pkg::REG_PRESS_C: cfg_q[esc_pkg::REG_PRESS_C] <= pwdata[47:0];
        esc_pkg::REG_HUM_A:   cfg_q[esc_pkg::REG_HUM_A]   <= {8'd0, pwdata[39:0]};
        esc_pkg::REG_HUM_B:   cfg_q[esc_pkg::REG_HUM_B]   <= {24'd0, pwdata[23:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    case (esc_pkg::reg_idx_e'(paddr[5:3]))
      esc_pkg::REG_TEMP:    prdata = {16'd0, cfg_q[esc_pkg::REG_TEMP]};
      esc_pkg::REG_PRESS_A: prdata = {16'd0, cfg_q[esc_pkg::REG_PRESS_A]};
      esc_pkg::REG_PRESS_B: prdata = {16'd0, cfg_q[esc_pkg::REG_PRESS_B]};
      esc_pkg::REG_PRESS_C: prdata = {16'd0, cfg_q[esc_pkg::REG_PRESS_C]};
      esc_pkg::REG_HUM_A:   prdata = {16'd0, cfg_q[esc_pkg::REG_HUM_A]};
      esc_pkg::REG_HUM_B:   prdata = {16'd0, cfg_q[esc_pkg::REG_HUM_B]};
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // coefficient fields
  logic [15:0]        t1_u;
  logic signed [15:0] t2_s, t3_s;
  logic signed [16:0] p1_s;
  logic signed [15:0] p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;
  logic signed [8:0]  h1_s, h3_s;
  logic signed [15:0] h2_s;
  logic signed [11:0] h4_s, h5_s;
  logic signed [7:0]  h6_s;

  assign t1_u = cfg_q[esc_pkg::REG_TEMP][15:0];
  assign t2_s = $signed(cfg_q[esc_pkg::REG_TEMP][31:16]);
  assign t3_s = $signed(cfg_q[esc_pkg::REG_TEMP][47:32]);
  assign p1_s = $signed({1'b0, cfg_q[esc_pkg::REG_PRESS_A][15:0]});
  assign p2_s = $signed(cfg_q[esc_pkg::REG_PRESS_A][31:16]);
  assign p3_s = $signed(cfg_q[esc_pkg::REG_PRESS_A][47:32]);
  assign p4_s = $signed(cfg_q[esc_pkg::REG_PRESS_B][15:0]);
  assign p5_s = $signed(cfg_q[esc_pkg::REG_PRESS_B][31:16]);
  assign p6_s = $signed(cfg_q[esc_pkg::REG_PRESS_B][47:32]);
  assign p7_s = $signed(cfg_q[esc_pkg::REG_PRESS_C][15:0]);
  assign p8_s = $signed(cfg_q[esc_pkg::REG_PRESS_C][31:16]);
  assign p9_s = $signed(cfg_q[esc_pkg::REG_PRESS_C][47:32]);
  assign h1_s = $signed({1'b0, cfg_q[esc_pkg::REG_HUM_A][7:0]});
  assign h2_s = $signed(cfg_q[esc_pkg::REG_HUM_A][23:8]);
  assign h3_s = $signed({1'b0, cfg_q[esc_pkg::REG_HUM_A][31:24]});
  assign h6_s = $signed(cfg_q[esc_pkg::REG_HUM_A][39:32]);
  assign h4_s = $signed(cfg_q[esc_pkg::REG_HUM_B][11:0]);
  assign h5_s = $signed(cfg_q[esc_pkg::REG_HUM_B][23:12]);

  // ---------------- pipeline control ----------------
  logic vld_q [1:NS];
  logic en;

  assign en             = !vld_q[NS] || result_o.ready;
  assign sample_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= sample_i.valid;
      for (int k = 2; k <= NS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // ---------------- datapath registers ----------------
  esc_pkg::sb_t sb_q [1:NS-1];
  esc_pkg::sb_t sb_d [2:NS-1];

  // fine temperature
  logic signed [35:0] m1_q, bb_q;
  logic signed [24:0] v1t_q;
  logic signed [37:0] m2_q;
  logic signed [23:0] tf_q, v1p_q, x_q;
  // pressure, ahead of the divider
  logic signed [47:0] sq_q;
  logic signed [39:0] mp5_q, mp2_q, mp5c_q, mp2c_q;
  logic signed [63:0] t6_q, t3_q, v2_q, mres_q;
  logic signed [55:0] y_q;
  logic [63:0]        pn_q, nm_q, ma_q;
  logic signed [30:0] d_q;
  logic [30:0]        mb_q;
  logic               neg_q;
  // divider
  logic [30:0] drem_q [ND];
  logic [63:0] dq_q   [ND];
  logic [30:0] dmb_q  [ND];
  logic        dneg_q [ND];
  // pressure, after the divider
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q, u_q, w_q, wc_q;
  logic [63:0]        ll_q, x9_q, s_q;
  logic [31:0]        c1_q, c2_q;
  logic signed [44:0] w19_q;
  // humidity
  logic signed [35:0] mh5_q;
  logic signed [31:0] mh6_q;
  logic signed [32:0] mh3_q;
  logic signed [20:0] s1_6_q, s1_7_q, s1_8_q;
  logic signed [21:0] a6_q;
  logic signed [22:0] b3_q;
  logic signed [44:0] in7_q;
  logic signed [46:0] mh2_q;
  logic signed [53:0] xx9_q, xx10_q, xx11_q;
  logic signed [63:0] sq2_q, hm_q;
  // output stage
  logic signed [esc_pkg::TEMP_W-1:0] out_temp_q;
  logic [esc_pkg::PRESS_W-1:0]       out_press_q;
  logic [esc_pkg::HUM_W-1:0]         out_hum_q;
  logic                              out_ts_q, out_ps_q, out_hs_q, out_dz_q;

  // ---------------- stage logic ----------------
  logic [63:0]        a_w, b_w, pr_w;
  logic signed [35:0] m1_d, bb_d;
  logic signed [24:0] v1t_d;
  logic signed [37:0] m2_d;
  logic signed [23:0] tf_d, v1p_d, x_d;
  logic signed [63:0] tt_w;
  logic signed [15:0] temp_d;
  logic signed [63:0] s1_w, hx_w, pp_w, pv_w;
  logic signed [30:0] in2_w;
  logic signed [32:0] s2_w;
  logic signed [35:0] sq_w;
  logic signed [56:0] hq_w;
  logic [28:0]        hc_w;
  logic [16:0]        hum_d;
  logic [63:0]        ae_w;
  logic [23:0]        press_d;

  always_comb begin
    // stage 1
    a_w  = {47'd0, sample_i.raw_temperature[19:3]} - {47'd0, t1_u, 1'b0};
    b_w  = {48'd0, sample_i.raw_temperature[19:4]} - {48'd0, t1_u};
    m1_d = $signed(a_w[18:0]) * t2_s;
    bb_d = $signed(b_w[17:0]) * $signed(b_w[17:0]);
    // stage 2
    v1t_d = 25'(m1_q >>> 11);
    m2_d  = $signed(bb_q[33:12]) * t3_s;
    // stage 3
    tf_d = 24'(v1t_q + (m2_q >>> 14));
    // stage 4
    tt_w  = (64'(tf_q) * 5 + 128) >>> 8;
    if (sb_q[3].t_skip) begin
      temp_d = '0;
    end else if (tt_w < -32768) begin
      temp_d = 16'sh8000;
    end else if (tt_w > 32767) begin
      temp_d = 16'sh7fff;
    end else begin
      temp_d = tt_w[15:0];
    end
    v1p_d = 24'(tf_q - 128000);
    x_d   = 24'(tf_q - 76800);
    // humidity, stage 6
    s1_w = ((64'($signed({1'b0, sb_q[5].rh})) <<< 14) - (64'(h4_s) <<< 20)
            - 64'(mh5_q) + 64'sd16384) >>> 15;
    // humidity, stages 8 to 12
    in2_w = 31'((in7_q >>> 10) + 2097152);
    s2_w  = 33'((mh2_q + 8192) >>> 14);
    sq_w  = 36'(xx9_q >>> 15);
    hq_w  = 57'(sq2_q >>> 7);
    hx_w  = 64'(xx11_q) - (hm_q >>> 4);
    if (hx_w < 0) begin
      hc_w = '0;
    end else if (hx_w > esc_pkg::HUM_CLAMP_MAX) begin
      hc_w = 29'(esc_pkg::HUM_CLAMP_MAX);
    end else begin
      hc_w = hx_w[28:0];
    end
    hum_d = sb_q[11].h_skip ? '0 : hc_w[28:12];
    // pressure numerator
    pr_w = 64'd1048576 - {44'd0, sb_q[7].rp};
    // sign-extended pressure over 2^13
    ae_w = 64'($signed(pb_q[63:13]));
    // final pressure
    pp_w = ($signed(s_q) >>> 8) + (64'(p7_s) <<< 4);
    pv_w = pp_w >>> 8;
    if (sb_q[NS-1].dz || sb_q[NS-1].p_skip || pv_w < 0) begin
      press_d = '0;
    end else if (pv_w > 64'sd16777215) begin
      press_d = 24'hffffff;
    end else begin
      press_d = pv_w[23:0];
    end
  end

  // side data shift, with results dropped in at their stages
  always_comb begin
    for (int k = 2; k < NS; k++) sb_d[k] = sb_q[k-1];
    sb_d[esc_pkg::ST_TEMP].temp = temp_d;
    sb_d[esc_pkg::ST_DZ].dz     = (d_q == '0);
    sb_d[esc_pkg::ST_HUM].hum   = hum_d;
  end

  // divider step: one restoring quotient bit per stage
  logic [30:0] drem_d [ND];
  logic [63:0] dq_d   [ND];

  always_comb begin
    logic [30:0] src_rem;
    logic [63:0] src_q;
    logic [30:0] src_mb;
    logic [31:0] trial;
    logic [31:0] diff;
    for (int k = 0; k < ND; k++) begin
      if (k == 0) begin
        src_rem = '0;
        src_q   = ma_q;
        src_mb  = mb_q;
      end else begin
        src_rem = drem_q[k-1];
        src_q   = dq_q[k-1];
        src_mb  = dmb_q[k-1];
      end
      trial = {src_rem, src_q[63]};
      diff  = trial - {1'b0, src_mb};
      if (trial >= {1'b0, src_mb}) begin
        drem_d[k] = diff[30:0];
        dq_d[k]   = {src_q[62:0], 1'b1};
      end else begin
        drem_d[k] = trial[30:0];
        dq_d[k]   = {src_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // side data
      sb_q[1] <= '{rp: sample_i.raw_pressure, rh: sample_i.raw_humidity,
                   t_skip: sample_i.raw_temperature == esc_pkg::TEMP_SKIP_CODE,
                   p_skip: sample_i.raw_pressure == esc_pkg::PRESS_SKIP_CODE,
                   h_skip: sample_i.raw_humidity == esc_pkg::HUM_SKIP_CODE,
                   dz: 1'b0, temp: '0, hum: '0};
      for (int k = 2; k < NS; k++) sb_q[k] <= sb_d[k];

      // fine temperature
      m1_q  <= m1_d;
      bb_q  <= bb_d;
      v1t_q <= v1t_d;
      m2_q  <= m2_d;
      tf_q  <= tf_d;
      v1p_q <= v1p_d;
      x_q   <= x_d;

      // pressure terms
      sq_q   <= v1p_q * v1p_q;
      mp5_q  <= v1p_q * p5_s;
      mp2_q  <= v1p_q * p2_s;
      t6_q   <= sq_q * p6_s;
      t3_q   <= sq_q * p3_s;
      mp5c_q <= mp5_q;
      mp2c_q <= mp2_q;
      v2_q   <= t6_q + (64'(mp5c_q) <<< 17) + (64'(p4_s) <<< 35);
      y_q    <= 56'(64'sh0000_8000_0000_0000 + (t3_q >>> 8) + (64'(mp2c_q) <<< 12));
      mres_q <= y_q * p1_s;
      pn_q   <= (pr_w << 31) - v2_q;
      d_q    <= $signed(mres_q[63:33]);
      nm_q   <= pn_q * 64'd3125;
      neg_q  <= nm_q[63] ^ d_q[30];
      ma_q   <= nm_q[63] ? (64'd0 - nm_q) : nm_q;
      mb_q   <= d_q[30] ? (31'd0 - d_q) : d_q;

      // divider
      for (int k = 0; k < ND; k++) begin
        drem_q[k] <= drem_d[k];
        dq_q[k]   <= dq_d[k];
      end
      dmb_q[0]  <= mb_q;
      dneg_q[0] <= neg_q;
      for (int k = 1; k < ND; k++) begin
        dmb_q[k]  <= dmb_q[k-1];
        dneg_q[k] <= dneg_q[k-1];
      end

      // pressure correction
      pa_q  <= dneg_q[ND-1] ? (64'd0 - dq_q[ND-1]) : dq_q[ND-1];
      u_q   <= p9_s * $signed(pa_q[63:13]);
      w_q   <= p8_s * pa_q;
      pb_q  <= pa_q;
      ll_q  <= u_q[31:0] * ae_w[31:0];
      c1_q  <= u_q[63:32] * ae_w[31:0];
      c2_q  <= u_q[31:0] * ae_w[63:32];
      wc_q  <= w_q;
      pc_q  <= pb_q;
      x9_q  <= ll_q + {c1_q + c2_q, 32'd0};
      w19_q <= 45'(wc_q >>> 19);
      pd_q  <= pc_q;
      s_q   <= pd_q + ($signed(x9_q) >>> 25) + 64'(w19_q);

      // humidity
      mh5_q  <= h5_s * x_q;
      mh6_q  <= x_q * h6_s;
      mh3_q  <= x_q * h3_s;
      s1_6_q <= 21'(s1_w);
      a6_q   <= 22'(mh6_q >>> 10);
      b3_q   <= 23'((mh3_q >>> 11) + 32768);
      in7_q  <= a6_q * b3_q;
      s1_7_q <= s1_6_q;
      mh2_q  <= in2_w * h2_s;
      s1_8_q <= s1_7_q;
      xx9_q  <= s1_8_q * s2_w;
      sq2_q  <= sq_w * sq_w;
      xx10_q <= xx9_q;
      hm_q   <= hq_w * h1_s;
      xx11_q <= xx10_q;

      // output register
      out_temp_q  <= sb_q[NS-1].temp;
      out_press_q <= press_d;
      out_hum_q   <= sb_q[NS-1].hum;
      out_ts_q    <= sb_q[NS-1].t_skip;
      out_ps_q    <= sb_q[NS-1].p_skip;
      out_hs_q    <= sb_q[NS-1].h_skip;
      out_dz_q    <= sb_q[NS-1].dz;
    end
  end

  assign result_o.valid             = vld_q[NS];
  assign result_o.temperature_centi = out_temp_q;
  assign result_o.pressure_pa       = out_press_q;
  assign result_o.humidity_q10      = out_hum_q;
  assign result_o.temp_skipped      = out_ts_q;
  assign result_o.press_skipped     = out_ps_q;
  assign result_o.hum_skipped       = out_hs_q;
  assign result_o.press_div_zero    = out_dz_q;

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the environmental sensor compensation pipeline
`timescale 1ns / 1ps
module testbench;

  localparam int LATENCY = 80;

  typedef struct packed {
    logic signed [esc_pkg::TEMP_W-1:0] temp;
    logic [esc_pkg::PRESS_W-1:0]       press;
    logic [esc_pkg::HUM_W-1:0]         hum;
    logic                              t_skip;
    logic                              p_skip;
    logic                              h_skip;
    logic                              dz;
  } comp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [esc_pkg::ADDR_W-1:0] paddr = '0;
  logic [esc_pkg::DATA_W-1:0] pwdata = '0;
  logic [esc_pkg::DATA_W-1:0] prdata;
  logic pready;

  esc_sample_if sample_if ();
  esc_result_if result_if ();

  env_sensor_compensation u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (result_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // coefficient shadow
  logic [esc_pkg::COEFF_W-1:0] coeff [esc_pkg::NUM_REGS];
  comp_t expected_q [$];
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int hold_cycles = 0;
  bit burst_mode = 1'b1;

  initial begin
    sample_if.valid = 1'b0;
    sample_if.raw_temperature = '0;
    sample_if.raw_pressure = '0;
    sample_if.raw_humidity = '0;
    result_if.ready = 1'b0;
    for (int i = 0; i < esc_pkg::NUM_REGS; i++) coeff[i] = '0;
  end

  function automatic logic signed [63:0] sx64(logic [63:0] v, int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    v = v & m;
    if (v[w-1]) v = v | ~m;
    return v;
  endfunction

  function automatic logic signed [63:0] sdiv64(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] ^ b[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(logic [esc_pkg::RAW_T_W-1:0] rt,
                                       logic [esc_pkg::RAW_P_W-1:0] rp,
                                       logic [esc_pkg::RAW_H_W-1:0] rh);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] h1, h2, h3, h4, h5, h6;
    logic signed [63:0] a, b, v1, v2, tf, t, p, x, s1, s2, inner, sq, pv, hv;
    comp_t r;
    t1 = coeff[esc_pkg::REG_TEMP][15:0];
    t2 = sx64(coeff[esc_pkg::REG_TEMP] >> 16, 16);
    t3 = sx64(coeff[esc_pkg::REG_TEMP] >> 32, 16);
    p1 = coeff[esc_pkg::REG_PRESS_A][15:0];
    p2 = sx64(coeff[esc_pkg::REG_PRESS_A] >> 16, 16);
    p3 = sx64(coeff[esc_pkg::REG_PRESS_A] >> 32, 16);
    p4 = sx64(coeff[esc_pkg::REG_PRESS_B], 16);
    p5 = sx64(coeff[esc_pkg::REG_PRESS_B] >> 16, 16);
    p6 = sx64(coeff[esc_pkg::REG_PRESS_B] >> 32, 16);
    p7 = sx64(coeff[esc_pkg::REG_PRESS_C], 16);
    p8 = sx64(coeff[esc_pkg::REG_PRESS_C] >> 16, 16);
    p9 = sx64(coeff[esc_pkg::REG_PRESS_C] >> 32, 16);
    h1 = coeff[esc_pkg::REG_HUM_A][7:0];
    h2 = sx64(coeff[esc_pkg::REG_HUM_A] >> 8, 16);
    h3 = coeff[esc_pkg::REG_HUM_A][31:24];
    h6 = sx64(coeff[esc_pkg::REG_HUM_A] >> 32, 8);
    h4 = sx64(coeff[esc_pkg::REG_HUM_B], 12);
    h5 = sx64(coeff[esc_pkg::REG_HUM_B] >> 12, 12);
    r.t_skip = (rt == esc_pkg::TEMP_SKIP_CODE);
    r.p_skip = (rp == esc_pkg::PRESS_SKIP_CODE);
    r.h_skip = (rh == esc_pkg::HUM_SKIP_CODE);

    // fine temperature
    a = $signed({44'd0, rt} >> 3) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    b = $signed({44'd0, rt} >> 4) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    t = (tf * 5 + 128) >>> 8;
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;
    if (r.t_skip) t = 0;
    r.temp = t[15:0];

    // pressure
    v1 = tf - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    r.dz = (v1 == 0);
    pv = 0;
    if (!r.dz) begin
      p = 64'sd1048576 - $signed({44'd0, rp});
      p = sdiv64(((p <<< 31) - v2) * 3125, v1);
      a = p >>> 13;
      v1 = (p9 * a * a) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      pv = p >>> 8;
      if (pv < 0) pv = 0;
      if (pv > 16777215) pv = 16777215;
    end
    if (r.p_skip) pv = 0;
    r.press = pv[23:0];

    // humidity, signed throughout
    x = tf - 76800;
    s1 = (($signed({48'd0, rh}) <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
    inner = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
    inner = (inner >>> 10) + 2097152;
    s2 = (inner * h2 + 8192) >>> 14;
    x = s1 * s2;
    sq = x >>> 15;
    x = x - ((((sq * sq) >>> 7) * h1) >>> 4);
    hv = x;
    if (hv < 0) hv = 0;
    if (hv > esc_pkg::HUM_CLAMP_MAX) hv = esc_pkg::HUM_CLAMP_MAX;
    hv = hv >>> 12;
    if (r.h_skip) hv = 0;
    r.hum = hv[16:0];
    return r;
  endfunction

  task automatic write_coeff(esc_pkg::reg_idx_e idx, logic [esc_pkg::COEFF_W-1:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = {16'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    coeff[idx] = value;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one sample set per call, starting at a falling edge; gaps come from the burst pattern
  task automatic send_sample(logic [esc_pkg::RAW_T_W-1:0] rt,
                             logic [esc_pkg::RAW_P_W-1:0] rp,
                             logic [esc_pkg::RAW_H_W-1:0] rh);
    if (burst_mode && $urandom_range(0, 7) == 0) begin
      sample_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    sample_if.valid = 1'b1;
    sample_if.raw_temperature = rt;
    sample_if.raw_pressure = rp;
    sample_if.raw_humidity = rh;
    do @(posedge clk_i); while (!sample_if.ready);
    expected_q.push_back(compensate(rt, rp, rh));
    samples_sent++;
    @(negedge clk_i);
    sample_if.valid = 1'b0;
  endtask

  // realistic calibration around typical factory values with random spread
  task automatic load_typical();
    write_coeff(esc_pkg::REG_TEMP, {16'($urandom_range(0, 200) - 100 + 65526 + 65536),
                                    16'(26000 + $urandom_range(0, 2000)),
                                    16'(27000 + $urandom_range(0, 2000))});
    write_coeff(esc_pkg::REG_PRESS_A, {16'(3024 + $urandom_range(0, 100) - 50 + 65536),
                                       16'(-10700 + int'($urandom_range(0, 200))),
                                       16'(36000 + $urandom_range(0, 2000))});
    write_coeff(esc_pkg::REG_PRESS_B, {16'(-7 + int'($urandom_range(0, 4))), 16'(-20),
                                       16'(7400 + $urandom_range(0, 400))});
    write_coeff(esc_pkg::REG_PRESS_C, {16'(4900 + $urandom_range(0, 200)),
                                       16'(-12000 + 65536),
                                       16'(60 + $urandom_range(0, 20))});
    write_coeff(esc_pkg::REG_HUM_A, {8'($urandom_range(20, 30)), 8'($urandom_range(0, 10)),
                                     16'(360 + $urandom_range(0, 20)),
                                     8'($urandom_range(60, 90))});
    write_coeff(esc_pkg::REG_HUM_B, {12'($urandom_range(40, 60)),
                                     12'($urandom_range(300, 340))});
  endtask

  task automatic load_random();
    for (int i = 0; i < esc_pkg::NUM_REGS; i++)
      write_coeff(esc_pkg::reg_idx_e'(i), 48'({$urandom, $urandom}));
  endtask

  task automatic test_directed_extremes();
    logic [esc_pkg::RAW_T_W-1:0] tv [6] = '{20'h0, 20'hFFFFF, esc_pkg::TEMP_SKIP_CODE,
                                            20'h7FFFF, 20'h80001, 20'd519888};
    load_typical();
    for (int i = 0; i < 6; i++)
      send_sample(tv[i], tv[5 - i], 16'(i * 13107));
    send_sample(20'd519888, esc_pkg::PRESS_SKIP_CODE, esc_pkg::HUM_SKIP_CODE);
    send_sample(20'd519888, 20'd415148, 16'hFFFF);
    send_sample(20'd519888, 20'd0, 16'h0);
    send_sample(esc_pkg::TEMP_SKIP_CODE, esc_pkg::PRESS_SKIP_CODE, esc_pkg::HUM_SKIP_CODE);
    send_sample(20'd519888, 20'hFFFFF, 16'h7FFF);
    drain();
  endtask

  task automatic test_zero_divisor();
    // P1 zero forces a zero divisor
    write_coeff(esc_pkg::REG_PRESS_A, 48'h0);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd519888, esc_pkg::PRESS_SKIP_CODE, 16'd30000);
    drain();
  endtask

  task automatic test_all_ones_and_zero();
    for (int i = 0; i < esc_pkg::NUM_REGS; i++) write_coeff(esc_pkg::reg_idx_e'(i), '1);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'h0, 20'h0, 16'h0);
    drain();
    for (int i = 0; i < esc_pkg::NUM_REGS; i++) write_coeff(esc_pkg::reg_idx_e'(i), '0);
    send_sample(20'h12345, 20'h54321, 16'h1234);
    drain();
  endtask

  task automatic random_phase(int n, bit typical);
    logic [esc_pkg::RAW_T_W-1:0] rt;
    logic [esc_pkg::RAW_P_W-1:0] rp;
    logic [esc_pkg::RAW_H_W-1:0] rh;
    for (int i = 0; i < n; i++) begin
      if (typical && $urandom_range(0, 9) != 0) begin
        rt = 20'($urandom_range(400000, 650000));
        rp = 20'($urandom_range(250000, 500000));
        rh = 16'($urandom_range(20000, 45000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
        rh = 16'($urandom);
        case ($urandom_range(0, 15))
          0: rt = esc_pkg::TEMP_SKIP_CODE;
          1: rp = esc_pkg::PRESS_SKIP_CODE;
          2: rh = esc_pkg::HUM_SKIP_CODE;
          default: ;
        endcase
      end
      send_sample(rt, rp, rh);
    end
  endtask

  task automatic test_random_typical();
    for (int k = 0; k < 4; k++) begin
      load_typical();
      random_phase(200, 1'b1);
      drain();
    end
  endtask

  task automatic test_random_coeffs();
    for (int k = 0; k < 4; k++) begin
      load_random();
      random_phase(100, 1'b0);
      drain();
    end
  endtask

  // long receiver hold with back-to-back offers, then a full pause and a phase with bursty offers
  task automatic test_backpressure();
    load_typical();
    burst_mode = 1'b0;
    hold_cycles = 300;
    random_phase(150, 1'b1);
    drain();
    burst_mode = 1'b1;
    random_phase(20, 1'b1);
    drain();
  endtask

  // receiver stall pattern, overridden by a long hold when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      result_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      result_if.ready <= ($urandom_range(0, 2) != 0);
    end else if (!result_if.ready) begin
      result_if.ready <= ($urandom_range(0, 1) == 0);
    end
  end

  always @(posedge clk_i) begin
    comp_t got, want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.temp = result_if.temperature_centi;
      got.press = result_if.pressure_pa;
      got.hum = result_if.humidity_q10;
      got.t_skip = result_if.temp_skipped;
      got.p_skip = result_if.press_skipped;
      got.h_skip = result_if.hum_skipped;
      got.dz = result_if.press_div_zero;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected %p got %p", results_seen, want, got);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(posedge clk_i);
    test_directed_extremes();
    test_zero_divisor();
    test_all_ones_and_zero();
    test_random_typical();
    test_random_coeffs();
    test_backpressure();
    $display("covered %0d sample sets and %0d results across typical, random and extreme",
             samples_sent, results_seen);
    $display("coefficients, skip codes, zero divisor and long output stalls");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- env_sensor_compensation.f -----
rtl/core/esc_pkg.sv
rtl/core/esc_sample_if.sv
rtl/core/esc_result_if.sv
rtl/core/env_sensor_compensation.sv
sim/testbench.sv
